FILE: hw/rtl/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
// Used by mtep_parser and midi_track_event_parser_unit; depends on nothing.
`timescale 1ns / 1ps

package mtep_pkg;

  localparam logic [1:0] FMT_PREFIX = 2'd0;
  localparam logic [1:0] FMT_SMF    = 2'd1;
  localparam logic [1:0] FMT_RAW    = 2'd2;

  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] PREFIX_DELAY   = 8'hF0;
  localparam logic [7:0] PREFIX_DELAY_HI = 8'hF1;
  localparam logic [7:0] SYSEX_START    = 8'hF0;
  localparam logic [7:0] SYSEX_END      = 8'hF7;
  localparam logic [7:0] META_START     = 8'hFF;
  localparam logic [7:0] SYSTEM_FIRST   = 8'hF0;
  localparam logic [3:0] MARKER_NIBBLE  = 4'hA;
  localparam logic [3:0] PROGRAM_NIBBLE = 4'hC;
  localparam logic [3:0] PRESSURE_NIBBLE = 4'hD;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_END       = 8'h2F;
  localparam logic [31:0] TEMPO_LEN     = 32'd3;
  localparam logic [31:0] MARKER_LEN    = 32'd2;
  localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;

  typedef enum logic [3:0] {
    PH_HEAD   = 4'd0,
    PH_STATUS = 4'd1,
    PH_DELAY  = 4'd2,
    PH_MARK   = 4'd3,
    PH_DATA1  = 4'd4,
    PH_DATA2  = 4'd5,
    PH_MTYPE  = 4'd6,
    PH_MLEN   = 4'd7,
    PH_MBODY  = 4'd8,
    PH_XLEN   = 4'd9,
    PH_XBODY  = 4'd10,
    PH_XWALK  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_NOOP    = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] delta;
    logic [7:0]  sticky_status;
    logic [7:0]  current_status;
    logic [7:0]  first_data;
    logic [7:0]  meta_code;
    logic [31:0] skip_remaining;
    logic [23:0] tempo;
    logic        first_pending;
    logic        ended;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] delta;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [23:0] tempo;
    logic        end_follows;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_HEAD, delta: '0, sticky_status: '0, current_status: '0,
    first_data: '0, meta_code: '0, skip_remaining: '0, tempo: '0,
    first_pending: 1'b1, ended: 1'b0
  };

endpackage

FILE: hw/rtl/mtep_parser.sv
// Parser state registers and the per-byte decode step.
// Depends on mtep_pkg for the state, phase and result types.
`timescale 1ns / 1ps

module mtep_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              sot_i,
  input  logic              last_i,
  input  logic [1:0]        fmt_i,
  output logic              res_valid_o,
  output mtep_pkg::result_t res_o
);

  mtep_pkg::state_t state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtep_pkg::STATE_RESET;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    mtep_pkg::state_t s;
    logic        do_prefix;
    logic        do_smf;
    logic        do_raw;
    logic        do_data1;
    logic        emit;
    logic        is_channel;
    mtep_pkg::kind_e kind;
    logic [7:0]  est;
    logic [7:0]  ed1;
    logic [7:0]  ed2;
    logic [23:0] etempo;
    logic [31:0] skip_dec;

    s          = sot_i ? mtep_pkg::STATE_RESET : state_q;
    do_prefix  = 1'b0;
    do_smf     = 1'b0;
    do_raw     = 1'b0;
    do_data1   = 1'b0;
    emit       = 1'b0;
    kind       = mtep_pkg::KIND_NOOP;
    est        = '0;
    ed1        = '0;
    ed2        = '0;
    etempo     = '0;
    is_channel = byte_i[7] && (byte_i < mtep_pkg::SYSTEM_FIRST);
    skip_dec   = s.skip_remaining - 32'd1;

    if (!s.ended) begin
      case (s.phase)
        mtep_pkg::PH_HEAD: begin
          if (fmt_i == mtep_pkg::FMT_PREFIX) begin
            do_prefix = 1'b1;
          end else if (fmt_i == mtep_pkg::FMT_RAW && s.first_pending) begin
            s.first_pending = 1'b0;
            s.delta         = '0;
            do_raw          = 1'b1;
          end else begin
            s.first_pending = 1'b0;
            s.delta         = {s.delta[24:0], byte_i[6:0]};
            if (!byte_i[7]) begin
              s.phase = mtep_pkg::PH_STATUS;
            end
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (fmt_i == mtep_pkg::FMT_PREFIX) begin
            do_prefix = 1'b1;
          end else if (fmt_i == mtep_pkg::FMT_RAW) begin
            do_raw = 1'b1;
          end else begin
            do_smf = 1'b1;
          end
        end
        mtep_pkg::PH_DELAY: begin
          s.delta = s.delta + {24'd0, byte_i}
                  + ((s.current_status == mtep_pkg::PREFIX_DELAY_HI) ? 32'd256 : 32'd0);
          s.phase = mtep_pkg::PH_HEAD;
        end
        mtep_pkg::PH_MARK: begin
          s.skip_remaining = skip_dec;
          if (skip_dec == '0) begin
            s.phase = mtep_pkg::PH_HEAD;
          end
        end
        mtep_pkg::PH_DATA1: begin
          do_data1 = 1'b1;
        end
        mtep_pkg::PH_DATA2: begin
          emit = 1'b1;
          kind = mtep_pkg::KIND_CHANNEL;
          est  = s.current_status;
          ed1  = s.first_data;
          ed2  = byte_i;
        end
        mtep_pkg::PH_MTYPE: begin
          s.meta_code      = byte_i;
          s.skip_remaining = '0;
          s.phase          = mtep_pkg::PH_MLEN;
        end
        mtep_pkg::PH_MLEN: begin
          s.skip_remaining = {s.skip_remaining[24:0], byte_i[6:0]};
          if (!byte_i[7]) begin
            if (s.meta_code == mtep_pkg::META_TEMPO &&
                s.skip_remaining != mtep_pkg::TEMPO_LEN) begin
              s.meta_code = '0;
            end
            s.tempo = '0;
            if (s.skip_remaining == '0) begin
              emit = 1'b1;
            end else begin
              s.phase = mtep_pkg::PH_MBODY;
            end
          end
        end
        mtep_pkg::PH_MBODY: begin
          if (s.meta_code == mtep_pkg::META_TEMPO) begin
            s.tempo = {s.tempo[15:0], byte_i};
          end
          s.skip_remaining = skip_dec;
          if (skip_dec == '0) begin
            emit = 1'b1;
          end
        end
        mtep_pkg::PH_XLEN: begin
          s.skip_remaining = {s.skip_remaining[24:0], byte_i[6:0]};
          if (!byte_i[7]) begin
            if (s.skip_remaining == '0) begin
              emit = 1'b1;
            end else begin
              s.phase = mtep_pkg::PH_XBODY;
            end
          end
        end
        mtep_pkg::PH_XBODY: begin
          s.skip_remaining = skip_dec;
          if (skip_dec == '0) begin
            emit = 1'b1;
          end
        end
        mtep_pkg::PH_XWALK: begin
          if (byte_i == mtep_pkg::SYSEX_END) begin
            emit = 1'b1;
          end
        end
        default: begin
          s.delta = '0;
          s.phase = mtep_pkg::PH_HEAD;
        end
      endcase

      // A finished meta event decides its own kind.
      if (emit && (s.phase == mtep_pkg::PH_MLEN || s.phase == mtep_pkg::PH_MBODY)) begin
        if (s.meta_code == mtep_pkg::META_END) begin
          kind = mtep_pkg::KIND_END;
        end else if (s.meta_code == mtep_pkg::META_TEMPO) begin
          kind   = mtep_pkg::KIND_TEMPO;
          etempo = (s.tempo == '0) ? mtep_pkg::DEFAULT_TEMPO : s.tempo;
        end
      end

      if (do_prefix) begin
        if (byte_i == mtep_pkg::PREFIX_DELAY || byte_i == mtep_pkg::PREFIX_DELAY_HI) begin
          s.current_status = byte_i;
          s.phase          = mtep_pkg::PH_DELAY;
        end else if (byte_i == mtep_pkg::META_START || byte_i == mtep_pkg::BYTE_ZERO) begin
          emit = 1'b1;
          kind = mtep_pkg::KIND_END;
        end else if (byte_i[7:4] == mtep_pkg::MARKER_NIBBLE) begin
          s.skip_remaining = mtep_pkg::MARKER_LEN;
          s.phase          = mtep_pkg::PH_MARK;
        end else if (!byte_i[7]) begin
          s.phase = mtep_pkg::PH_HEAD;
        end else begin
          s.current_status = byte_i;
          s.phase          = mtep_pkg::PH_DATA1;
        end
      end

      if (do_smf || do_raw) begin
        if (is_channel) begin
          s.sticky_status  = byte_i;
          s.current_status = byte_i;
          s.phase          = mtep_pkg::PH_DATA1;
        end else if (byte_i == mtep_pkg::SYSEX_START || byte_i == mtep_pkg::SYSEX_END) begin
          s.sticky_status = '0;
          if (do_raw) begin
            s.phase = mtep_pkg::PH_XWALK;
          end else begin
            s.skip_remaining = '0;
            s.phase          = mtep_pkg::PH_XLEN;
          end
        end else if (byte_i == mtep_pkg::META_START) begin
          if (do_raw) begin
            emit = 1'b1;
            kind = mtep_pkg::KIND_END;
          end else begin
            s.sticky_status = '0;
            s.phase         = mtep_pkg::PH_MTYPE;
          end
        end else if (byte_i[7]) begin
          s.sticky_status = '0;
          s.delta         = '0;
          s.phase         = mtep_pkg::PH_HEAD;
        end else if (s.sticky_status != '0) begin
          s.current_status = s.sticky_status;
          do_data1         = 1'b1;
        end else if (do_raw) begin
          emit = 1'b1;
          kind = mtep_pkg::KIND_END;
        end else begin
          s.delta = {24'd0, byte_i};
          s.phase = mtep_pkg::PH_STATUS;
        end
      end

      if (do_data1) begin
        s.first_data = byte_i;
        if (s.current_status[7:4] == mtep_pkg::PROGRAM_NIBBLE ||
            s.current_status[7:4] == mtep_pkg::PRESSURE_NIBBLE) begin
          emit = 1'b1;
          kind = mtep_pkg::KIND_CHANNEL;
          est  = s.current_status;
          ed1  = byte_i;
        end else begin
          s.phase = mtep_pkg::PH_DATA2;
        end
      end

      if (!emit && last_i) begin
        emit = 1'b1;
        kind = (s.phase == mtep_pkg::PH_XWALK) ? mtep_pkg::KIND_NOOP : mtep_pkg::KIND_END;
      end
    end

    res_o.kind        = kind;
    res_o.delta       = s.delta;
    res_o.status      = est;
    res_o.data_one    = ed1;
    res_o.data_two    = ed2;
    res_o.tempo       = etempo;
    res_o.end_follows = last_i;
    res_valid_o       = emit;

    if (emit) begin
      s.delta = '0;
      s.phase = mtep_pkg::PH_HEAD;
      if (kind == mtep_pkg::KIND_END || last_i) begin
        s.ended = 1'b1;
      end
    end
    state_d = s;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> state_q.ended)
    else $error("Track not marked ended after its last byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == mtep_pkg::KIND_END |=> state_q.ended)
    else $error("End of track event did not end the track.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !sot_i && state_q.ended |-> !res_valid_o)
    else $error("Event produced after the track ended.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o |=> state_q.delta == '0 && state_q.phase == mtep_pkg::PH_HEAD)
    else $error("Delta or phase not cleared after an event.");

endmodule

FILE: hw/rtl/midi_track_event_parser_unit.sv
// Top level of the MIDI track event parser: input register, format register,
// output register. Depends on mtep_pkg and mtep_parser.
//
//   Channel  Direction  Handshake                     Carries
//   s_axis   in         s_axis_tvalid/s_axis_tready   track byte, start flag, last flag
//   m_axis   out        m_axis_tvalid/m_axis_tready   one decoded event
//   cfg      in         cfg_valid_i/cfg_ready_o       track_format
//
// One track byte is accepted per cycle while m_axis does not stall. A byte is
// decoded while it sits in the input register, and its event, if any, is held in
// the output register and valid on m_axis. A byte that finishes no event leaves
// nothing on m_axis. Reset sets the format to standard MIDI track and the parser
// to track start. When m_axis stalls, the held event and one held input byte fill
// up, then s_axis_tready drops until the event is taken.
`timescale 1ns / 1ps

module midi_track_event_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // track_byte
  input  logic        s_axis_tuser,   // start_of_track
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // event delta, status_byte, data_one,
                                      // data_two, tempo_us_per_quarter
  output logic [1:0]  m_axis_tuser,   // event_kind
  output logic        m_axis_tlast,   // end_follows
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              in_sot_q;
  logic              in_last_q;
  logic              out_valid_q, out_valid_d;
  mtep_pkg::result_t out_q;
  logic [1:0]        fmt_q;
  logic              advance;
  logic              res_valid;
  mtep_pkg::result_t res;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tvalid || (in_valid_q && !advance);

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (advance) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fmt_q       <= mtep_pkg::FMT_SMF;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= in_valid_d;
      end
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        fmt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_sot_q  <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  mtep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .sot_i       (in_sot_q),
    .last_i      (in_last_q),
    .fmt_i       (fmt_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.tempo, out_q.data_two, out_q.data_one,
                          out_q.status, out_q.delta};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.end_follows;

endmodule
